### design/msc_pkg.sv
// shared types and constants for the multi-source switch combiner
package msc_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned PERIOD_W = 32;

	localparam logic [2:0] REG_UPDATE_PERIOD = 3'd0;
	localparam logic [2:0] REG_COMBINE_OP = 3'd1;
	localparam logic [2:0] REG_MISSING_POLICY = 3'd2;
	localparam logic [2:0] REG_DEFAULT_VALUE = 3'd3;
	localparam logic [2:0] REG_ENABLED = 3'd4;

	localparam logic [1:0] OP_FIRST = 2'd0;
	localparam logic [1:0] OP_AND = 2'd1;
	localparam logic [1:0] OP_OR = 2'd2;
	localparam logic [1:0] OP_BAD = 2'd3;

	localparam logic [1:0] POL_FAIL = 2'd0;
	localparam logic [1:0] POL_IGNORE = 2'd1;
	localparam logic [1:0] POL_DEFAULT = 2'd2;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOTCONF = 3'd1,
		ST_NOVALID = 3'd2,
		ST_SRCERR = 3'd3,
		ST_STALE = 3'd4,
		ST_BADOP = 3'd5,
		ST_SKIP = 3'd6
	} status_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] update_period;
		logic [1:0] combine_op;
		logic [1:0] missing_policy;
		logic default_value;
		logic enabled;
	} cfg_t;

	typedef struct packed {
		logic time_ok;
		logic value_ok;
		logic source_value;
		logic first_of_update;
		logic last_of_update;
	} flags_t;

	typedef struct packed {
		status_t status;
		logic switch_value;
		logic error_flag;
		logic updated;
		logic alarm;
	} res_t;

endpackage

### design/multi_source_switch_combiner.sv
// top level of the multi-source switch combiner
//
// source reports enter on the input channel (in_valid / in_stall), one field
// per port; a report with first_of_update opens an update and a report with
// last_of_update closes it. only the closing report produces a transfer on
// the output channel (out_valid / out_stall) carrying status, switch_value,
// error_flag, updated and alarm.
// a report is registered on acceptance, evaluated from the input register
// against the stored run state, and a closing report's result is registered
// in the output register, which drives out_valid.
// without a stall, one report per cycle is accepted; the single-bit run
// accumulator and stored switch state update in that same evaluation cycle.
// when the receiver stalls, the result is held in the output register; a
// closing report then waits in the input register and in_stall rises,
// while non-closing reports keep flowing.
// reset clears the valid flags, the configuration, the run state and the
// stored value, with run status no valid source. the user must write the apb
// configuration only while no update is in flight; it is not enforced.
module multi_source_switch_combiner #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [msc_pkg::ADDR_W-1:0] paddr,
	input logic [msc_pkg::DATA_W-1:0] pwdata,
	output logic [msc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [TIME_WIDTH-1:0] now_time,
	input logic [TIME_WIDTH-1:0] source_time,
	input logic time_ok,
	input logic value_ok,
	input logic source_value,
	input logic first_of_update,
	input logic last_of_update,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic switch_value,
	output logic error_flag,
	output logic updated,
	output logic alarm
);
	import msc_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic out_valid_q;

	logic valid_s1;
	logic [TIME_WIDTH-1:0] now_s1, src_s1;
	flags_t flags_s1;
	logic advance;

	msc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign advance = valid_s1 && (!flags_s1.last_of_update || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1 <= now_time;
			src_s1 <= source_time;
			flags_s1 <= '{time_ok, value_ok, source_value, first_of_update, last_of_update};
		end
	end

	msc_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.fire(advance),
		.now_time(now_s1),
		.source_time(src_s1),
		.flags(flags_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && flags_s1.last_of_update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flags_s1.last_of_update) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign switch_value = res_q.switch_value;
	assign error_flag = res_q.error_flag;
	assign updated = res_q.updated;
	assign alarm = res_q.alarm;

endmodule

### design/msc_cfg.sv
// apb configuration registers of the switch combiner
module msc_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [msc_pkg::ADDR_W-1:0] paddr,
	input logic [msc_pkg::DATA_W-1:0] pwdata,
	output logic [msc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output msc_pkg::cfg_t cfg
);
	import msc_pkg::*;

	cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_UPDATE_PERIOD: cfg_q.update_period <= pwdata[PERIOD_W-1:0];
				REG_COMBINE_OP: cfg_q.combine_op <= pwdata[1:0];
				REG_MISSING_POLICY: cfg_q.missing_policy <= pwdata[1:0];
				REG_DEFAULT_VALUE: cfg_q.default_value <= pwdata[0];
				REG_ENABLED: cfg_q.enabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_UPDATE_PERIOD: prdata = cfg_q.update_period;
			REG_COMBINE_OP: prdata = {30'd0, cfg_q.combine_op};
			REG_MISSING_POLICY: prdata = {30'd0, cfg_q.missing_policy};
			REG_DEFAULT_VALUE: prdata = {31'd0, cfg_q.default_value};
			REG_ENABLED: prdata = {31'd0, cfg_q.enabled};
			default: prdata = '0;
		endcase
	end

endmodule

### design/msc_core.sv
// per-report evaluation, run state and stored switch state
module msc_core #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input msc_pkg::cfg_t cfg,
	input logic fire,
	input logic [TIME_WIDTH-1:0] now_time,
	input logic [TIME_WIDTH-1:0] source_time,
	input msc_pkg::flags_t flags,
	output msc_pkg::res_t res
);
	import msc_pkg::*;

	logic stored_value_q, value_valid_q, error_state_q;
	logic acc_q, got_valid_q, run_done_q;
	status_t run_status_q;
	logic [TIME_WIDTH-1:0] last_time_q, update_now_q;

	logic n_stored, n_vvalid, n_err, n_acc, n_gv, n_done;
	status_t n_status;
	logic [TIME_WIDTH-1:0] n_last, n_now;

	logic [TIME_WIDTH-1:0] per;
	assign per = TIME_WIDTH'(cfg.update_period);

	always_comb begin
		logic [TIME_WIDTH-1:0] tsrc;
		logic [TIME_WIDTH-1:0] diff;
		logic stale;
		logic do_comb;
		logic val;
		status_t err;

		n_stored = stored_value_q;
		n_vvalid = value_valid_q;
		n_err = error_state_q;
		n_acc = acc_q;
		n_gv = got_valid_q;
		n_done = run_done_q;
		n_status = run_status_q;
		n_last = last_time_q;
		n_now = update_now_q;
		res = '0;
		tsrc = source_time;
		diff = '0;
		stale = 1'b0;
		do_comb = 1'b0;
		val = flags.source_value;
		err = ST_OK;

		if (flags.first_of_update) begin
			n_now = now_time;
			n_gv = 1'b0;
			n_acc = (cfg.combine_op == OP_AND);
			n_status = ST_NOVALID;
			n_done = 1'b0;
			if (!cfg.enabled) begin
				n_status = ST_NOTCONF;
				n_done = 1'b1;
			end else if (((now_time - last_time_q) < per) && value_valid_q) begin
				n_status = ST_SKIP;
				n_done = 1'b1;
			end
		end

		if (!n_done) begin
			if (!flags.time_ok) begin
				if (cfg.missing_policy == POL_DEFAULT) begin
					tsrc = n_now;
				end else begin
					err = ST_SRCERR;
				end
			end
			diff = n_now - tsrc;
			stale = (per[TIME_WIDTH-1:TIME_WIDTH-2] == 2'b00) && !diff[TIME_WIDTH-1]
				&& (diff > {per[TIME_WIDTH-3:0], 2'b00});
			if (err == ST_OK) begin
				if (!flags.value_ok) begin
					err = ST_SRCERR;
				end else if (stale) begin
					err = ST_STALE;
				end
			end
			if (err != ST_OK) begin
				priority if (cfg.missing_policy == POL_IGNORE) begin
					n_status = n_gv ? ST_OK : err;
				end else if (cfg.missing_policy == POL_DEFAULT) begin
					val = cfg.default_value;
					do_comb = 1'b1;
				end else begin
					n_status = err;
					n_done = 1'b1;
				end
			end else begin
				n_gv = 1'b1;
				do_comb = 1'b1;
			end
			if (do_comb) begin
				n_status = ST_OK;
				unique case (cfg.combine_op)
					OP_AND: n_acc = n_acc & val;
					OP_OR: n_acc = n_acc | val;
					OP_FIRST: begin
						n_acc = val;
						n_done = 1'b1;
					end
					OP_BAD: begin
						n_acc = val;
						n_status = ST_BADOP;
						n_done = 1'b1;
					end
					default: ;
				endcase
			end
		end

		if (flags.last_of_update) begin
			n_done = 1'b1;
			res.status = n_status;
			priority case (n_status)
				ST_SKIP: res.status = ST_OK;
				ST_NOTCONF: ;
				ST_OK: begin
					n_stored = n_acc;
					n_last = n_now;
					n_err = 1'b0;
					n_vvalid = 1'b1;
					res.updated = 1'b1;
				end
				default: begin
					n_err = 1'b1;
					res.alarm = (cfg.missing_policy != POL_IGNORE);
				end
			endcase
			res.switch_value = n_stored;
			res.error_flag = n_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_value_q <= 1'b0;
			value_valid_q <= 1'b0;
			error_state_q <= 1'b0;
			acc_q <= 1'b0;
			got_valid_q <= 1'b0;
			run_done_q <= 1'b0;
			run_status_q <= ST_NOVALID;
			last_time_q <= '0;
			update_now_q <= '0;
		end else if (fire) begin
			stored_value_q <= n_stored;
			value_valid_q <= n_vvalid;
			error_state_q <= n_err;
			acc_q <= n_acc;
			got_valid_q <= n_gv;
			run_done_q <= n_done;
			run_status_q <= n_status;
			last_time_q <= n_last;
			update_now_q <= n_now;
		end
	end

	a_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire && flags.last_of_update |=> run_done_q)
		else $error("run not closed after last report");

	a_update_clears_error: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.updated |=> !error_state_q && value_valid_q)
		else $error("stored update left error state");

	a_alarm_not_updated: assert property (@(posedge clk) disable iff (!arst_n)
		res.alarm |-> !res.updated && res.error_flag)
		else $error("alarm raised on a successful update");

	a_notconf_keeps_value: assert property (@(posedge clk) disable iff (!arst_n)
		fire && flags.last_of_update && res.status == ST_NOTCONF
		|=> $stable(stored_value_q) && $stable(error_state_q))
		else $error("not configured update changed stored state");

endmodule

### tb/tb_multi_source_switch_combiner.sv
`timescale 1ns / 100ps
// self-checking testbench: source-report traffic on the combiner, results checked by a predictor
module tb_multi_source_switch_combiner;
	import msc_pkg::*;

	typedef struct packed {
		logic [31:0] now_t;
		logic [31:0] src_t;
		flags_t flags;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] now_time = '0;
	logic [31:0] source_time = '0;
	logic time_ok = 1'b0;
	logic value_ok = 1'b0;
	logic source_value = 1'b0;
	logic first_of_update = 1'b0;
	logic last_of_update = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic switch_value;
	logic error_flag;
	logic updated;
	logic alarm;

	// register copies
	logic [31:0] cfg_period = '0;
	logic [1:0] cfg_op = OP_FIRST;
	logic [1:0] cfg_policy = POL_FAIL;
	logic cfg_default = 1'b0;
	logic cfg_enabled = 1'b0;

	// combiner state as predicted
	logic held_value = 1'b0;
	logic held_valid = 1'b0;
	logic [31:0] held_time = '0;
	logic fault = 1'b0;
	logic acc = 1'b0;
	logic seen_good = 1'b0;
	logic run_closed = 1'b0;
	status_t run_status = ST_NOVALID;
	logic [31:0] run_now = '0;

	report_t pending_reports[$];
	res_t awaited_results[$];
	report_t on_wire;
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	bit sender_idle = 1'b1;
	bit recv_idle = 1'b1;
	logic [31:0] tick_now = '0;

	multi_source_switch_combiner dut (.*);

	always #4 clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_v);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, exp_v, $realtime);
		mismatches++;
	endtask

	function automatic logic too_old(input logic [31:0] now_v, input logic [31:0] src_v);
		logic [31:0] diff;
		logic [33:0] lim;
		diff = now_v - src_v;
		lim = {cfg_period, 2'b00};
		if (cfg_period > 32'h3FFF_FFFF)
			return 1'b0;
		return ({2'b00, diff} > lim) && (diff <= 32'h7FFF_FFFF);
	endfunction

	task automatic fold_report(input report_t r);
		res_t want;
		status_t err;
		logic [31:0] t_src;
		logic v;
		if (r.flags.first_of_update) begin
			run_now = r.now_t;
			seen_good = 1'b0;
			acc = (cfg_op == OP_AND);
			run_status = ST_NOVALID;
			run_closed = 1'b0;
			if (!cfg_enabled) begin
				run_status = ST_NOTCONF;
				run_closed = 1'b1;
			end else if ((run_now - held_time) < cfg_period && held_valid) begin
				run_status = ST_SKIP;
				run_closed = 1'b1;
			end
		end
		if (!run_closed) begin
			t_src = r.src_t;
			v = r.flags.source_value;
			err = ST_OK;
			if (!r.flags.time_ok) begin
				if (cfg_policy == POL_DEFAULT)
					t_src = run_now;
				else
					err = ST_SRCERR;
			end
			if (err == ST_OK) begin
				if (!r.flags.value_ok)
					err = ST_SRCERR;
				else if (too_old(run_now, t_src))
					err = ST_STALE;
			end
			if (err != ST_OK && cfg_policy == POL_IGNORE) begin
				run_status = seen_good ? ST_OK : err;
			end else if (err != ST_OK && cfg_policy != POL_DEFAULT) begin
				run_status = err;
				run_closed = 1'b1;
			end else begin
				if (err != ST_OK)
					v = cfg_default;
				else
					seen_good = 1'b1;
				run_status = ST_OK;
				case (cfg_op)
				OP_AND: acc = acc & v;
				OP_OR: acc = acc | v;
				OP_FIRST: begin
					acc = v;
					run_closed = 1'b1;
				end
				default: begin
					acc = v;
					run_status = ST_BADOP;
					run_closed = 1'b1;
				end
				endcase
			end
		end
		if (r.flags.last_of_update) begin
			run_closed = 1'b1;
			want.status = run_status;
			want.updated = 1'b0;
			want.alarm = 1'b0;
			case (run_status)
			ST_SKIP: want.status = ST_OK;
			ST_NOTCONF: ;
			ST_OK: begin
				held_value = acc;
				held_time = run_now;
				fault = 1'b0;
				held_valid = 1'b1;
				want.updated = 1'b1;
			end
			default: begin
				fault = 1'b1;
				want.alarm = (cfg_policy != POL_IGNORE);
			end
			endcase
			want.switch_value = held_value;
			want.error_flag = fault;
			awaited_results.push_back(want);
		end
	endtask

	task automatic add_report(input logic [31:0] now_v, input logic [31:0] src_v,
			input logic tok, input logic vok, input logic sval, input logic fst, input logic lst);
		report_t r;
		r.now_t = now_v;
		r.src_t = src_v;
		r.flags.time_ok = tok;
		r.flags.value_ok = vok;
		r.flags.source_value = sval;
		r.flags.first_of_update = fst;
		r.flags.last_of_update = lst;
		pending_reports.push_back(r);
	endtask

	task automatic add_noise();
		add_report($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
	endtask

	task automatic queue_update(input int n_src);
		logic [31:0] quad;
		logic [31:0] age;
		quad = cfg_period << 2;
		case ($urandom_range(0, 5))
		0: ;
		1: tick_now += cfg_period - 1;
		2: tick_now += cfg_period;
		3: tick_now += $urandom_range(1, 40);
		4: tick_now += $urandom;
		default: tick_now += cfg_period + $urandom_range(0, 20);
		endcase
		for (int i = 0; i < n_src; i++) begin
			case ($urandom_range(0, 6))
			0: age = '0;
			1: age = $urandom_range(0, quad);
			2: age = quad;
			3: age = quad + 1;
			4: age = quad + $urandom_range(2, 50);
			5: age = 32'd0 - $urandom_range(1, 1000);
			default: age = $urandom;
			endcase
			add_report(tick_now, tick_now - age, $urandom_range(0, 7) != 0,
				$urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), i == 0, i == n_src - 1);
		end
	endtask

	task automatic fill_phase(input int n_items);
		int count;
		int n;
		count = 0;
		while (count < n_items) begin
			if ($urandom_range(0, 9) != 0) begin
				n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
				queue_update(n);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) add_noise();
			end
			count += n;
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_UPDATE_PERIOD: cfg_period = val;
		REG_COMBINE_OP: cfg_op = val[1:0];
		REG_MISSING_POLICY: cfg_policy = val[1:0];
		REG_DEFAULT_VALUE: cfg_default = val[0];
		REG_ENABLED: cfg_enabled = val[0];
		default: ;
		endcase
	endtask

	task automatic load_setup(input logic [31:0] per, input logic [1:0] op,
			input logic [1:0] pol, input logic dflt, input logic en);
		write_reg(REG_UPDATE_PERIOD, per);
		write_reg(REG_COMBINE_OP, {30'd0, op});
		write_reg(REG_MISSING_POLICY, {30'd0, pol});
		write_reg(REG_DEFAULT_VALUE, {31'd0, dflt});
		write_reg(REG_ENABLED, {31'd0, en});
		@(negedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		while (pending_reports.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	always @(posedge clk) begin : source_side
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				fold_report(on_wire);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (sender_idle && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 16);
				end else if (pending_reports.size() != 0) begin
					on_wire = pending_reports.pop_front();
					now_time <= on_wire.now_t;
					source_time <= on_wire.src_t;
					time_ok <= on_wire.flags.time_ok;
					value_ok <= on_wire.flags.value_ok;
					source_value <= on_wire.flags.source_value;
					first_of_update <= on_wire.flags.first_of_update;
					last_of_update <= on_wire.flags.last_of_update;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	always @(posedge clk) begin : result_side
		res_t want;
		logic next_stall;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result with none expected", {29'd0, status}, 32'd0);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status)
						flag_mismatch("status", {29'd0, status}, {29'd0, want.status});
					if (switch_value !== want.switch_value)
						flag_mismatch("switch_value", {31'd0, switch_value},
							{31'd0, want.switch_value});
					if (error_flag !== want.error_flag)
						flag_mismatch("error_flag", {31'd0, error_flag},
							{31'd0, want.error_flag});
					if (updated !== want.updated)
						flag_mismatch("updated", {31'd0, updated}, {31'd0, want.updated});
					if (alarm !== want.alarm)
						flag_mismatch("alarm", {31'd0, alarm}, {31'd0, want.alarm});
				end
			end
			next_stall = 1'b0;
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 150;
			end
			if (hold_left != 0) begin
				hold_left--;
				next_stall = 1'b1;
			end else if (recv_gap != 0) begin
				recv_gap--;
				next_stall = 1'b1;
			end else if (recv_idle && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 16);
				next_stall = 1'b1;
			end
			out_stall <= next_stall;
		end
	end

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [31:0] per;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset setup has the switch disabled
		add_report(32'd100, 32'd90, 1, 1, 1, 1, 1);
		settle();

		load_setup(32'd16, OP_AND, POL_FAIL, 1'b1, 1'b1);
		add_report(32'd100, 32'd96, 1, 1, 1, 1, 0);
		add_report(32'd100, 32'd100, 1, 1, 1, 0, 1);
		// period not elapsed with a valid value: skipped
		add_report(32'd105, 32'd100, 1, 1, 0, 1, 1);
		// now at the top of the range, one source exactly at the limit, one ahead of now
		add_report(32'hFFFF_FFFF, 32'hFFFF_FFBF, 1, 1, 1, 1, 0);
		add_report(32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 0, 0, 1);
		// one tick past the stale limit across the wrap
		add_report(32'h20, 32'hFFFF_FFDF, 1, 1, 1, 1, 1);
		// time fetch error under fail policy closes the run early
		add_report(32'h60, 32'h60, 0, 1, 1, 1, 0);
		add_report(32'h60, 32'h60, 1, 1, 1, 0, 0);
		add_report(32'h60, 32'h60, 1, 1, 1, 0, 1);
		// closing report with no opening
		add_report(32'h80, 32'h80, 1, 1, 1, 0, 1);
		add_report(32'h80, 32'h80, 1, 0, 1, 1, 0);
		add_report(32'h80, 32'h80, 1, 1, 1, 0, 1);
		settle();

		load_setup(32'd16, OP_OR, POL_IGNORE, 1'b0, 1'b1);
		add_report(32'h100, 32'h100, 1, 1, 0, 1, 0);
		add_report(32'h100, 32'h100, 0, 1, 1, 0, 0);
		add_report(32'h100, 32'h0, 1, 0, 1, 0, 1);
		add_report(32'h200, 32'h0, 1, 1, 1, 1, 1);
		settle();

		load_setup(32'd16, OP_FIRST, POL_DEFAULT, 1'b1, 1'b1);
		add_report(32'h300, 32'h1_2345, 0, 1, 0, 1, 1);
		add_report(32'h400, 32'h400, 1, 0, 0, 1, 1);
		settle();

		load_setup(32'd0, OP_BAD, 2'd3, 1'b0, 1'b1);
		add_report(32'h500, 32'h500, 1, 1, 0, 1, 0);
		add_report(32'h500, 32'h500, 1, 1, 1, 0, 1);
		add_report(32'h600, 32'h0, 1, 0, 1, 1, 1);
		settle();

		for (int ph = 0; ph < 14; ph++) begin
			case (ph % 7)
			0: per = 32'd0;
			1: per = 32'd1;
			2: per = $urandom_range(2, 60);
			3: per = 32'h3FFF_FFFF;
			4: per = 32'h4000_0000;
			5: per = 32'hFFFF_FFFF;
			default: per = $urandom_range(0, 300);
			endcase
			load_setup(per, 2'(ph % 4), 2'((ph / 4) % 4), 1'($urandom_range(0, 1)), ph != 9);
			if (ph >= 12) begin
				sender_idle = 1'b0;
				recv_idle = 1'b0;
			end
			fill_phase(48);
			settle();

			if (ph == 6) begin
				// long receiver hold-off while reports keep coming
				load_setup(32'd0, OP_OR, POL_IGNORE, 1'b0, 1'b1);
				sender_idle = 1'b0;
				recv_idle = 1'b0;
				hold_req++;
				repeat (40) queue_update(1);
				settle();
				sender_idle = 1'b1;
				recv_idle = 1'b1;
			end
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
